/* sv/epm_pkg.sv */
// Shared constants, codes and types for the exact pattern matcher.
`timescale 1ns / 1ps
`default_nettype none

package epm_pkg;

    // Default sizing of the cell chain and the position counter
    localparam int PATTERN_MAX_DEF   = 64;
    localparam int CHAR_BITS_DEF     = 8;
    localparam int POSITION_BITS_DEF = 32;

    // Fixed port widths
    localparam int LEN_REG_W = 7;
    localparam int INDEX_W   = 6;
    localparam int DATA_W    = 8;
    localparam int START_W   = 32;

    localparam logic [LEN_REG_W-1:0] LEN_RESET = LEN_REG_W'(1);

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_TEXT = 1'b1
    } epm_action_t;

    // Per-transfer control broadcast to every cell
    typedef struct packed {
        logic               text_en;
        logic               load_en;
        logic [INDEX_W-1:0] load_index;
        logic               last;
    } epm_cell_ctrl_t;

endpackage

`default_nettype wire

/* sv/epm_cell.sv */
// One matcher cell: a pattern symbol and the prefix bit that ends at it.
`timescale 1ns / 1ps
`default_nettype none

module epm_cell #(
    parameter int CHAR_BITS  = epm_pkg::CHAR_BITS_DEF,
    parameter int LEN_W      = 7,
    parameter int CELL_INDEX = 0
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire epm_pkg::epm_cell_ctrl_t ctrl,
    input  wire logic [CHAR_BITS-1:0]   sym,
    input  wire logic [LEN_W-1:0]       len_sat,
    input  wire logic                   prefix_in,
    output logic                        prefix_out,
    output logic                        hit
);

    logic [CHAR_BITS-1:0] pattern_reg;
    logic                 prefix_reg;
    logic                 prefix_next;
    logic                 in_use;
    logic                 is_top;
    logic                 extend;

    assign in_use = 32'(len_sat) > 32'(CELL_INDEX);
    assign is_top = 32'(len_sat) == 32'(CELL_INDEX + 1);
    assign extend = prefix_in && in_use && (pattern_reg == sym);
    assign hit    = extend && is_top;

    // Drop all prefixes after the final symbol of a text
    always_comb begin
        prefix_next = prefix_reg;
        if (ctrl.text_en) begin
            prefix_next = ctrl.last ? 1'b0 : extend;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= 1'b0;
        end else begin
            prefix_reg <= prefix_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_en &&
            (32'(ctrl.load_index) == 32'(CELL_INDEX))) begin
            pattern_reg <= sym;
        end
    end

    assign prefix_out = prefix_reg;

endmodule

`default_nettype wire

/* sv/exact_pattern_matcher.sv */
// Top level of the exact pattern matcher: cell chain, position counter, output skid.
// The result of a text byte is registered into the output register, or into the skid entry while the output is stalled.
// Throughput: one item per cycle while s_ready is high; every cell updates its prefix bit in the same cycle.
// A two-entry output (register plus skid) keeps s_ready high while one result waits.
// Reset (aresetn low, synchronous): prefix bits, position and the output and skid valid flags clear, length is 1.
// The pattern symbols are not reset and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module exact_pattern_matcher #(
    parameter int PATTERN_MAX   = epm_pkg::PATTERN_MAX_DEF,
    parameter int CHAR_BITS     = epm_pkg::CHAR_BITS_DEF,
    parameter int POSITION_BITS = epm_pkg::POSITION_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [epm_pkg::LEN_REG_W-1:0] cfg_wdata,
    // input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [epm_pkg::INDEX_W-1:0]   s_pattern_index,
    input  wire logic [epm_pkg::DATA_W-1:0]    s_data_byte,
    input  wire logic                          s_last_of_text,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_match_found,
    output logic [epm_pkg::START_W-1:0]        m_match_start
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Configuration register
    logic [epm_pkg::LEN_REG_W-1:0] pattern_length_reg;
    logic [epm_pkg::LEN_REG_W-1:0] pattern_length_next;
    logic [LEN_W-1:0]              len_sat;

    // Text position of the next byte
    logic [POSITION_BITS-1:0] position_reg;
    logic [POSITION_BITS-1:0] position_next;

    // Output register and skid entry
    logic                        out_valid_reg, out_valid_next;
    logic                        out_found_reg, out_found_next;
    logic [epm_pkg::START_W-1:0] out_start_reg, out_start_next;
    logic                        skid_valid_reg, skid_valid_next;
    logic                        skid_found_reg, skid_found_next;
    logic [epm_pkg::START_W-1:0] skid_start_reg, skid_start_next;

    logic                        in_fire;
    logic                        text_fire;
    logic                        res_found;
    logic [epm_pkg::START_W-1:0] res_start;
    logic [POSITION_BITS-1:0]    start_pos;
    logic [CHAR_BITS-1:0]        sym;

    epm_pkg::epm_cell_ctrl_t cell_ctrl;
    logic [PATTERN_MAX:0]    prefix_chain;
    logic [PATTERN_MAX-1:0]  hit_vec;

    // Accept while the skid entry is free
    assign s_ready   = !skid_valid_reg;
    assign in_fire   = s_valid && s_ready;
    assign text_fire = in_fire && (s_action == epm_pkg::ACT_TEXT);

    // Symbols wider than the data port see zeros in their upper bits
    assign sym = CHAR_BITS'(s_data_byte);

    // Saturate the length to the number of cells
    assign len_sat = (32'(pattern_length_reg) > 32'(PATTERN_MAX)) ?
                     LEN_W'(PATTERN_MAX) : LEN_W'(pattern_length_reg);

    always_comb begin
        pattern_length_next = pattern_length_reg;
        if (cfg_we) begin
            pattern_length_next = cfg_wdata;
        end
    end

    always_comb begin
        cell_ctrl.text_en    = text_fire;
        cell_ctrl.load_en    = in_fire && (s_action == epm_pkg::ACT_LOAD);
        cell_ctrl.load_index = s_pattern_index;
        cell_ctrl.last       = s_last_of_text;
    end

    // Cell 0 always sees the empty prefix from the left
    assign prefix_chain[0] = 1'b1;

    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
        epm_cell #(
            .CHAR_BITS  (CHAR_BITS),
            .LEN_W      (LEN_W),
            .CELL_INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .sym        (sym),
            .len_sat    (len_sat),
            .prefix_in  (prefix_chain[i]),
            .prefix_out (prefix_chain[i+1]),
            .hit        (hit_vec[i])
        );
    end

    // Only the cell at the pattern's last position can raise a hit
    assign res_found = |hit_vec;

    // The occurrence starts len-1 bytes before the current position
    assign start_pos = POSITION_BITS'(position_reg - POSITION_BITS'(len_sat)
                                      + POSITION_BITS'(1));
    assign res_start = res_found ? epm_pkg::START_W'(start_pos) : '0;

    // Advance the position per text byte; clear it after the last byte
    always_comb begin
        position_next = position_reg;
        if (text_fire) begin
            position_next = s_last_of_text ? '0 :
                            POSITION_BITS'(position_reg + POSITION_BITS'(1));
        end
    end

    // Output register with a one-entry skid behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_found_next  = out_found_reg;
        out_start_next  = out_start_reg;
        skid_valid_next = skid_valid_reg;
        skid_found_next = skid_found_reg;
        skid_start_next = skid_start_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                // advance the waiting result; the skid is full, so s_ready was low and no new one came in
                out_valid_next  = 1'b1;
                out_found_next  = skid_found_reg;
                out_start_next  = skid_start_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = text_fire;
                out_found_next = res_found;
                out_start_next = res_start;
            end
        end else if (text_fire) begin
            // hold the output and park the new result
            skid_valid_next = 1'b1;
            skid_found_next = res_found;
            skid_start_next = res_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_length_reg <= epm_pkg::LEN_RESET;
            position_reg       <= '0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            pattern_length_reg <= pattern_length_next;
            position_reg       <= position_next;
            out_valid_reg      <= out_valid_next;
            skid_valid_reg     <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_found_reg  <= out_found_next;
        out_start_reg  <= out_start_next;
        skid_found_reg <= skid_found_next;
        skid_start_reg <= skid_start_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_match_found = out_found_reg;
    assign m_match_start = out_start_reg;

endmodule

`default_nettype wire

/* sv/epm_checker.sv */
// Port-level assertions for the exact pattern matcher and their bind.
`timescale 1ns / 1ps
`default_nettype none

module epm_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          s_action,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic                          m_match_found,
    input wire logic [epm_pkg::START_W-1:0]   m_match_start
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_match_found) && $stable(m_match_start))
        else $error("result changed while stalled");

    // A transferred text byte always leaves a result waiting
    a_text_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_action == epm_pkg::ACT_TEXT) |=> m_valid)
        else $error("text transfer produced no result");

    // Input backpressure only with a result pending
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // No start position without a match
    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_match_found |-> m_match_start == '0)
        else $error("start position set without a match");

    // Reset drops any pending result
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind exact_pattern_matcher epm_checker u_epm_checker (.*);

`default_nettype wire

/* test/epm_match_checker.sv */
// Transfer monitor, occurrence predictor and result comparison for the exact pattern matcher.
`timescale 1ns / 1ps

module epm_match_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [epm_pkg::LEN_REG_W-1:0] cfg_wdata,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire logic                          s_action,
    input  wire logic [epm_pkg::INDEX_W-1:0]   s_pattern_index,
    input  wire logic [epm_pkg::DATA_W-1:0]    s_data_byte,
    input  wire logic                          s_last_of_text,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic                          m_match_found,
    input  wire logic [epm_pkg::START_W-1:0]   m_match_start,
    output int                                 mismatch_count,
    output int                                 results_pending
);

    typedef struct packed {
        logic                        found;
        logic [epm_pkg::START_W-1:0] start;
    } match_result_t;

    logic [epm_pkg::DATA_W-1:0]          pattern_copy [epm_pkg::PATTERN_MAX_DEF];
    logic [epm_pkg::PATTERN_MAX_DEF-1:0] prefix_bits;
    logic [epm_pkg::START_W-1:0]         text_pos;
    logic [epm_pkg::LEN_REG_W-1:0]       match_length;
    match_result_t                       expected_matches [$];
    int                                  errors_seen = 0;

    assign mismatch_count = errors_seen;

    task automatic report_mismatch(input string what);
        errors_seen++;
        $display("[%0t] %s", $time, what);
    endtask

    // Advance the shift-and state by one text byte and return the occurrence it ends.
    function automatic match_result_t scan_symbol(input logic [epm_pkg::DATA_W-1:0] symbol,
                                                  input logic last);
        match_result_t r;
        int            span;
        span = (int'(match_length) > epm_pkg::PATTERN_MAX_DEF) ?
               epm_pkg::PATTERN_MAX_DEF : int'(match_length);
        r = '0;
        prefix_bits = {prefix_bits[epm_pkg::PATTERN_MAX_DEF-2:0], 1'b1};
        for (int i = 0; i < epm_pkg::PATTERN_MAX_DEF; i++) begin
            if (i >= span || pattern_copy[i] != symbol)
                prefix_bits[i] = 1'b0;
        end
        if (span > 0 && prefix_bits[span-1]) begin
            r.found = 1'b1;
            r.start = text_pos - epm_pkg::START_W'(span - 1);
        end
        if (last) begin
            prefix_bits = '0;
            text_pos    = '0;
        end else begin
            text_pos = text_pos + 1'b1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        match_result_t want;
        if (!aresetn) begin
            match_length = epm_pkg::LEN_RESET;
            prefix_bits  = '0;
            text_pos     = '0;
            expected_matches.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_matches.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: found %0b start %0d",
                                              m_match_found, m_match_start));
                end else begin
                    want = expected_matches.pop_front();
                    if (m_match_found !== want.found)
                        report_mismatch($sformatf("match_found got %0b, want %0b",
                                                  m_match_found, want.found));
                    if (m_match_start !== want.start)
                        report_mismatch($sformatf("match_start got %0d, want %0d",
                                                  m_match_start, want.start));
                end
            end
            if (cfg_we)
                match_length = cfg_wdata;
            if (s_valid && s_ready) begin
                if (s_action == epm_pkg::ACT_LOAD)
                    pattern_copy[s_pattern_index] = s_data_byte;
                else
                    expected_matches.push_back(scan_symbol(s_data_byte, s_last_of_text));
            end
        end
        results_pending <= expected_matches.size();
    end

endmodule

/* test/tb.sv */
// Top of the exact pattern matcher testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;

    localparam int LIMIT_CYCLES  = 200_000;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_ITEMS = 40;
    localparam int HOLD_CYCLES   = 60;
    localparam int SETTLE_CYCLES = 4;

    // Every block input starts at a known value.
    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          cfg_we          = 1'b0;
    logic [epm_pkg::LEN_REG_W-1:0] cfg_wdata       = '0;
    logic                          s_valid         = 1'b0;
    logic                          s_action        = epm_pkg::ACT_LOAD;
    logic [epm_pkg::INDEX_W-1:0]   s_pattern_index = '0;
    logic [epm_pkg::DATA_W-1:0]    s_data_byte     = '0;
    logic                          s_last_of_text  = 1'b0;
    logic                          m_ready         = 1'b0;

    wire                           s_ready;
    wire                           m_valid;
    wire                           m_match_found;
    wire  [epm_pkg::START_W-1:0]   m_match_start;

    int mismatch_count;
    int results_pending;

    // Flow-control knobs, in percent of cycles spent idle.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long receiver hold-off: requested by the stimulus, timed by the receiver process.
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_left = 0;

    int cycle_count = 0;

    // Mirror of what the stimulus has loaded, used to build occurrences.
    logic [epm_pkg::DATA_W-1:0]          pattern_image [epm_pkg::PATTERN_MAX_DEF];
    bit   [epm_pkg::PATTERN_MAX_DEF-1:0] loaded      = '0;
    int                                  active_len  = 1;
    int                                  items_sent  = 0;

    // Lengths per random segment: extremes (0, 1, 64, 127), small values and values around 32 and 64.
    int segment_lengths [SEGMENTS] = '{3, 127, 1, 0, 64, 2, 5, 32, 33, 65, 4, 63};

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    exact_pattern_matcher uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_pattern_index (s_pattern_index),
        .s_data_byte     (s_data_byte),
        .s_last_of_text  (s_last_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_found   (m_match_found),
        .m_match_start   (m_match_start)
    );

    epm_match_checker match_monitor (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_pattern_index (s_pattern_index),
        .s_data_byte     (s_data_byte),
        .s_last_of_text  (s_last_of_text),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_match_found   (m_match_found),
        .m_match_start   (m_match_start),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // Receiver: random back-pressure, or a solid hold-off once requested.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run if it never drains.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("exact_pattern_matcher: mismatch");
            $finish;
        end
    end

    // Offer one item and hold it until the transfer. Valid drops only inside an idle
    // gap, so a back-to-back item never sees valid lowered and raised in one step.
    task automatic send_item(input logic action, input logic [epm_pkg::INDEX_W-1:0] index,
                             input logic [epm_pkg::DATA_W-1:0] value, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_action        <= action;
        s_pattern_index <= index;
        s_data_byte     <= value;
        s_last_of_text  <= last;
        do @(posedge aclk); while (!s_ready);
        if (action == epm_pkg::ACT_LOAD) begin
            pattern_image[index] = value;
            loaded[index]        = 1'b1;
        end
        items_sent++;
    endtask

    task automatic load_byte(input logic [epm_pkg::INDEX_W-1:0] index,
                             input logic [epm_pkg::DATA_W-1:0] value);
        send_item(epm_pkg::ACT_LOAD, index, value, $urandom_range(1));
    endtask

    // The index field is unused on text items; randomize it anyway.
    task automatic text_byte(input logic [epm_pkg::DATA_W-1:0] value, input logic last);
        send_item(epm_pkg::ACT_TEXT, epm_pkg::INDEX_W'($urandom), value, last);
    endtask

    // Stop offering and wait until every expected result has been taken. The extra
    // cycles cover a trailing load, which produces no result.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Change the length only while idle. Text state is left alone, so any prefix
    // still in flight meets the new length on the next text byte.
    task automatic write_length(input int value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= epm_pkg::LEN_REG_W'(value);
        @(posedge aclk);
        cfg_we     <= 1'b0;
        active_len  = (value > epm_pkg::PATTERN_MAX_DEF) ? epm_pkg::PATTERN_MAX_DEF : value;
    endtask

    // Refresh the head of the pattern from a small alphabet so that overlapping
    // occurrences are common; fill any entry in use that was never written.
    task automatic prepare_pattern();
        logic [epm_pkg::DATA_W-1:0] symbols [3];
        int                         kinds;
        int                         slot;
        bit                         descending;
        kinds = $urandom_range(3, 1);
        foreach (symbols[k]) symbols[k] = epm_pkg::DATA_W'($urandom);
        descending = $urandom_range(1);
        for (int i = 0; i < active_len; i++) begin
            slot = descending ? active_len - 1 - i : i;
            if (slot < 8 || !loaded[slot])
                load_byte(epm_pkg::INDEX_W'(slot), symbols[$urandom_range(kinds - 1)]);
        end
    endtask

    // Mostly well-formed text: whole occurrences, broken prefixes and bytes from the
    // pattern's own alphabet, with loads mid-text, text ends and plain noise mixed in.
    task automatic emit_text(input int budget);
        int first_count;
        int pick;
        int cut;
        first_count = items_sent;
        while (items_sent - first_count < budget) begin
            pick = $urandom_range(99);
            if (active_len == 0 || pick >= 85) begin
                if (pick >= 95)
                    load_byte(epm_pkg::INDEX_W'($urandom_range(epm_pkg::PATTERN_MAX_DEF - 1)),
                              epm_pkg::DATA_W'($urandom));
                else
                    text_byte(epm_pkg::DATA_W'($urandom), $urandom_range(7) == 0);
            end else if (pick < 40) begin
                for (int i = 0; i < active_len; i++)
                    text_byte(pattern_image[i], (i == active_len - 1) && ($urandom_range(9) == 0));
            end else if (pick < 50) begin
                cut = $urandom_range(active_len - 1);
                for (int i = 0; i < cut; i++)
                    text_byte(pattern_image[i], 1'b0);
            end else if (pick < 75) begin
                text_byte(pattern_image[$urandom_range(active_len - 1)], 1'b0);
            end else if (pick < 80) begin
                load_byte(epm_pkg::INDEX_W'($urandom_range(active_len - 1)),
                          pattern_image[$urandom_range(active_len - 1)]);
            end else begin
                text_byte(pattern_image[$urandom_range(active_len - 1)], 1'b1);
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset length of one, extreme index and byte values.
        load_byte(6'd0, 8'h00);
        load_byte(6'd63, 8'hFF);
        text_byte(8'h00, 1'b0);
        text_byte(8'hFF, 1'b0);
        text_byte(8'h00, 1'b1);     // occurrence on the last byte, then text restarts
        text_byte(8'h00, 1'b0);     // position counts from zero again

        // Length zero never matches but still answers every text byte.
        write_length(0);
        text_byte(8'h00, 1'b0);
        text_byte(8'hFF, 1'b1);

        // Overlapping occurrences, then a pattern rewrite in the middle of the text.
        write_length(2);
        load_byte(6'd0, 8'h5A);
        load_byte(6'd1, 8'h5A);
        text_byte(8'h5A, 1'b0);
        text_byte(8'h5A, 1'b0);
        text_byte(8'h5A, 1'b0);
        load_byte(6'd1, 8'hA5);
        text_byte(8'hA5, 1'b0);
        text_byte(8'h5A, 1'b0);

        // Shrink the length with a one-byte prefix still live.
        write_length(1);
        text_byte(8'h5A, 1'b1);

        // Random segments in three flow-control phases: slow receiver, slow sender, none.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 0) begin
                send_idle_pct = 19;
                recv_idle_pct = 84;
            end else if (seg == SEGMENTS / 3) begin
                send_idle_pct = 84;
                recv_idle_pct = 19;
            end else if (seg == 2 * SEGMENTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_length(segment_lengths[seg]);
            prepare_pattern();
            // Block the result side for a long stretch while text keeps coming.
            if (seg == 2)
                hold_req = 1'b1;
            emit_text(SEGMENT_ITEMS);
        end

        settle();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("exact_pattern_matcher: match");
        else
            $display("exact_pattern_matcher: mismatch");
        $finish;
    end

endmodule

/* files.f */
sv/epm_pkg.sv
sv/epm_cell.sv
sv/exact_pattern_matcher.sv
sv/epm_checker.sv
test/epm_match_checker.sv
test/tb.sv
